// File: src/cri_pkg.sv
// ----------------------------------------------------------------------------
// cri_pkg
// shared types, constants and the cordic angle table for the ray/circle
// intersection pipeline
// ----------------------------------------------------------------------------
package cri_pkg;

    // number formats
    localparam int ANGLE_BITS   = 16;
    localparam int FRAC_BITS    = 16;
    localparam int DIR_FRAC     = 29;
    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 31;

    // cordic start value, pre-scaled by the inverse gain
    localparam logic signed [31:0] CORDIC_GAIN_START = 32'sd326016437;

    // forward epsilon (1e-6) in the q format, rounded to nearest
    localparam longint EPS_Q = ((64'sd1 <<< FRAC_BITS) + 64'sd500000) / 64'sd1000000;

    // tag carried along the cordic chain
    typedef struct packed {
        logic [1:0]         quad;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [32:0] ocx;
        logic signed [32:0] ocy;
    } ray_tag_t;

    // word moving through one cordic cell
    typedef struct packed {
        logic               valid;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        ray_tag_t           tag;
    } cordic_word_t;

    // tag carried along the square root chain
    typedef struct packed {
        logic signed [36:0] b;
        logic               miss;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
    } sqrt_tag_t;

    // word moving through one square root cell
    typedef struct packed {
        logic        valid;
        logic [63:0] rem;
        logic [63:0] res;
        sqrt_tag_t   tag;
    } sqrt_word_t;

    // result word
    typedef struct packed {
        logic               hit;
        logic [30:0]        t_dist;
        logic signed [31:0] px;
        logic signed [31:0] py;
    } out_word_t;

    // arctangent of 2^-step, 2^32 units per turn
    function automatic logic signed [31:0] atan_step(input logic [4:0] step);
        logic signed [31:0] v;
        case (step)
            5'd0:    v = 32'sd536870912;
            5'd1:    v = 32'sd316933406;
            5'd2:    v = 32'sd167458907;
            5'd3:    v = 32'sd85004756;
            5'd4:    v = 32'sd42667331;
            5'd5:    v = 32'sd21354465;
            5'd6:    v = 32'sd10679838;
            5'd7:    v = 32'sd5340245;
            5'd8:    v = 32'sd2670163;
            5'd9:    v = 32'sd1335087;
            5'd10:   v = 32'sd667544;
            5'd11:   v = 32'sd333772;
            5'd12:   v = 32'sd166886;
            5'd13:   v = 32'sd83443;
            5'd14:   v = 32'sd41722;
            5'd15:   v = 32'sd20861;
            5'd16:   v = 32'sd10430;
            5'd17:   v = 32'sd5215;
            5'd18:   v = 32'sd2608;
            5'd19:   v = 32'sd1304;
            5'd20:   v = 32'sd652;
            5'd21:   v = 32'sd326;
            5'd22:   v = 32'sd163;
            5'd23:   v = 32'sd81;
            5'd24:   v = 32'sd41;
            5'd25:   v = 32'sd20;
            5'd26:   v = 32'sd10;
            5'd27:   v = 32'sd5;
            5'd28:   v = 32'sd3;
            5'd29:   v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: src/cri_cordic_cell.sv
// ----------------------------------------------------------------------------
// cri_cordic_cell
// one cordic rotation step with its pipeline register
// ----------------------------------------------------------------------------
module cri_cordic_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [4:0]            step,
    input  cri_pkg::cordic_word_t in_word,
    output cri_pkg::cordic_word_t out_word
);

    logic                  valid_reg;
    cri_pkg::cordic_word_t data_reg;
    cri_pkg::cordic_word_t data_next;
    logic signed [31:0]    xs;
    logic signed [31:0]    ys;
    logic signed [31:0]    ang;

    // rotate toward zero residual angle
    always_comb
    begin
        xs        = $signed(in_word.x) >>> step;
        ys        = $signed(in_word.y) >>> step;
        ang       = cri_pkg::atan_step(step);
        data_next = in_word;
        if (!in_word.z[31])
        begin
            data_next.x = in_word.x - ys;
            data_next.y = in_word.y + xs;
            data_next.z = in_word.z - ang;
        end
        else
        begin
            data_next.x = in_word.x + ys;
            data_next.y = in_word.y - xs;
            data_next.z = in_word.z + ang;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_word.valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    always_comb
    begin
        out_word       = data_reg;
        out_word.valid = valid_reg;
    end

endmodule

// File: src/cri_sqrt_cell.sv
// ----------------------------------------------------------------------------
// cri_sqrt_cell
// one digit of the restoring integer square root with its pipeline register
// ----------------------------------------------------------------------------
module cri_sqrt_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic [4:0]          step,
    input  cri_pkg::sqrt_word_t in_word,
    output cri_pkg::sqrt_word_t out_word
);

    logic                valid_reg;
    cri_pkg::sqrt_word_t data_reg;
    cri_pkg::sqrt_word_t data_next;
    logic [63:0]         bit_val;
    logic [63:0]         trial;

    // try the current bit pair
    always_comb
    begin
        bit_val   = 64'd1 << (6'd60 - {step, 1'b0});
        trial     = in_word.res + bit_val;
        data_next = in_word;
        if (in_word.rem >= trial)
        begin
            data_next.rem = in_word.rem - trial;
            data_next.res = (in_word.res >> 1) + bit_val;
        end
        else
        begin
            data_next.res = in_word.res >> 1;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_word.valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    always_comb
    begin
        out_word       = data_reg;
        out_word.valid = valid_reg;
    end

endmodule

// File: src/cri_out_buf.sv
// ----------------------------------------------------------------------------
// cri_out_buf
// two-word output buffer that decouples the pipeline from the output stall
// ----------------------------------------------------------------------------
module cri_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cri_pkg::out_word_t push_word,
    input  logic               pop,
    output logic               full,
    output logic               valid,
    output cri_pkg::out_word_t head
);

    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    cri_pkg::out_word_t head_reg;
    cri_pkg::out_word_t head_next;
    cri_pkg::out_word_t tail_reg;
    cri_pkg::out_word_t tail_next;

    // slot update
    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        if (push && pop)
        begin
            if (count_reg == 2'd1)
                head_next = push_word;
            else
            begin
                head_next = tail_reg;
                tail_next = push_word;
            end
        end
        else if (push)
        begin
            count_next = count_reg + 2'd1;
            if (count_reg == 2'd0)
                head_next = push_word;
            else
                tail_next = push_word;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
            head_next  = tail_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = head_reg;

endmodule

// File: src/circle_ray_intersect.sv
// ----------------------------------------------------------------------------
// circle_ray_intersect
// ray against circle intersection in q16.16, cordic direction, square root
// discriminant, nearest forward root and hit point
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake         payload
//  in       input      in_valid/in_stall origin_x, origin_y, angle
//  out      output     out_valid/out_stall hit, distance_t, point_x, point_y
//  cfg      input      apb write/read    circle center x/y, radius
//
//  one word enters per cycle while in_stall is low
//  the pipeline holds the 30 cordic cells and the 31 square root cells
//  a two-word output buffer takes results; in_stall rises only when it is full
//  reset clears all valid flags and loads the configuration reset values
//
module circle_ray_intersect (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] origin_x,
    input  logic [31:0] origin_y,
    input  logic [15:0] angle,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic [30:0] distance_t,
    output logic [31:0] point_x,
    output logic [31:0] point_y,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] REG_CTR_X  = 2'd0;
    localparam logic [1:0] REG_CTR_Y  = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    localparam int N_CORDIC = cri_pkg::CORDIC_STEPS;
    localparam int N_SQRT   = cri_pkg::SQRT_STEPS;

    // configuration registers
    logic signed [31:0] ctr_x_reg;
    logic signed [31:0] ctr_y_reg;
    logic [30:0]        radius_reg;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_x_reg  <= 32'sd0;
            ctr_y_reg  <= 32'sd0;
            radius_reg <= 31'd65536;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_CTR_X:  ctr_x_reg  <= pwdata;
                REG_CTR_Y:  ctr_y_reg  <= pwdata;
                REG_RADIUS: radius_reg <= pwdata[30:0];
                default:    ;
            endcase
        end
    end

    // register read
    always_comb
    begin
        case (paddr[3:2])
            REG_CTR_X:  prdata = ctr_x_reg;
            REG_CTR_Y:  prdata = ctr_y_reg;
            REG_RADIUS: prdata = {1'b0, radius_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // pipeline enable
    logic               buf_full;
    logic               en;
    cri_pkg::out_word_t out_head;

    assign en       = !buf_full;
    assign in_stall = buf_full;

    // angle reduction to nearest quarter turn, offset from center
    logic [31:0]           a32;
    logic [31:0]           a32_bias;
    logic [1:0]            quad_in;
    cri_pkg::cordic_word_t cw [0:N_CORDIC];

    always_comb
    begin
        a32      = {angle, {(32 - cri_pkg::ANGLE_BITS){1'b0}}};
        a32_bias = a32 + 32'h2000_0000;
        quad_in  = a32_bias[31:30];
        cw[0].valid    = in_valid;
        cw[0].x        = cri_pkg::CORDIC_GAIN_START;
        cw[0].y        = 32'sd0;
        cw[0].z        = a32 - {quad_in, 30'd0};
        cw[0].tag.quad = quad_in;
        cw[0].tag.ox   = origin_x;
        cw[0].tag.oy   = origin_y;
        cw[0].tag.ocx  = 33'($signed(origin_x)) - 33'(ctr_x_reg);
        cw[0].tag.ocy  = 33'($signed(origin_y)) - 33'(ctr_y_reg);
    end

    // cordic chain
    for (genvar k = 0; k < N_CORDIC; k++)
    begin : g_cordic
        cri_cordic_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .step     (5'(k)),
            .in_word  (cw[k]),
            .out_word (cw[k+1])
        );
    end

    // quadrant restore
    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [32:0] ocx;
        logic signed [32:0] ocy;
    } ray_keep_t;

    logic               dir_valid_reg;
    logic signed [31:0] dir_dx_reg, dir_dy_reg;
    logic signed [31:0] dir_dx_next, dir_dy_next;
    ray_keep_t          dir_keep_reg;

    always_comb
    begin
        case (cw[N_CORDIC].tag.quad)
            QUAD_0:
            begin
                dir_dx_next = cw[N_CORDIC].x;
                dir_dy_next = cw[N_CORDIC].y;
            end
            QUAD_1:
            begin
                dir_dx_next = -cw[N_CORDIC].y;
                dir_dy_next = cw[N_CORDIC].x;
            end
            QUAD_2:
            begin
                dir_dx_next = -cw[N_CORDIC].x;
                dir_dy_next = -cw[N_CORDIC].y;
            end
            default:
            begin
                dir_dx_next = cw[N_CORDIC].y;
                dir_dy_next = -cw[N_CORDIC].x;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dir_dx_reg       <= dir_dx_next;
            dir_dy_reg       <= dir_dy_next;
            dir_keep_reg.ox  <= cw[N_CORDIC].tag.ox;
            dir_keep_reg.oy  <= cw[N_CORDIC].tag.oy;
            dir_keep_reg.ocx <= cw[N_CORDIC].tag.ocx;
            dir_keep_reg.ocy <= cw[N_CORDIC].tag.ocy;
        end
    end

    // dot and cross products
    logic               mul_valid_reg;
    logic signed [64:0] m_bx_reg, m_by_reg, m_px_reg, m_py_reg;
    logic signed [31:0] mul_ox_reg, mul_oy_reg, mul_dx_reg, mul_dy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_bx_reg   <= dir_keep_reg.ocx * dir_dx_reg;
            m_by_reg   <= dir_keep_reg.ocy * dir_dy_reg;
            m_px_reg   <= dir_keep_reg.ocx * dir_dy_reg;
            m_py_reg   <= dir_keep_reg.ocy * dir_dx_reg;
            mul_ox_reg <= dir_keep_reg.ox;
            mul_oy_reg <= dir_keep_reg.oy;
            mul_dx_reg <= dir_dx_reg;
            mul_dy_reg <= dir_dy_reg;
        end
    end

    // rounded b and p, miss test
    logic               bp_valid_reg;
    logic signed [65:0] sum_b, sum_p, rnd_b, rnd_p;
    logic signed [36:0] p_val;
    logic [36:0]        ap_val;
    logic signed [36:0] bp_b_reg;
    logic [30:0]        bp_ap_reg;
    logic               bp_miss_reg;
    logic signed [31:0] bp_ox_reg, bp_oy_reg, bp_dx_reg, bp_dy_reg;

    always_comb
    begin
        sum_b  = 66'(m_bx_reg) + 66'(m_by_reg);
        sum_p  = 66'(m_px_reg) - 66'(m_py_reg);
        rnd_b  = (sum_b + 66'sd268435456) >>> cri_pkg::DIR_FRAC;
        rnd_p  = (sum_p + 66'sd268435456) >>> cri_pkg::DIR_FRAC;
        p_val  = rnd_p[36:0];
        ap_val = p_val[36] ? 37'(-p_val) : 37'(p_val);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bp_b_reg    <= rnd_b[36:0];
            bp_ap_reg   <= ap_val[30:0];
            bp_miss_reg <= ap_val > {6'd0, radius_reg};
            bp_ox_reg   <= mul_ox_reg;
            bp_oy_reg   <= mul_oy_reg;
            bp_dx_reg   <= mul_dx_reg;
            bp_dy_reg   <= mul_dy_reg;
        end
    end

    // squares
    logic               sq_valid_reg;
    logic [61:0]        sq_rr_reg, sq_pp_reg;
    cri_pkg::sqrt_tag_t sq_tag_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_rr_reg       <= 62'(radius_reg) * 62'(radius_reg);
            sq_pp_reg       <= 62'(bp_ap_reg) * 62'(bp_ap_reg);
            sq_tag_reg.b    <= bp_b_reg;
            sq_tag_reg.miss <= bp_miss_reg;
            sq_tag_reg.ox   <= bp_ox_reg;
            sq_tag_reg.oy   <= bp_oy_reg;
            sq_tag_reg.dx   <= bp_dx_reg;
            sq_tag_reg.dy   <= bp_dy_reg;
        end
    end

    // quarter discriminant
    logic               ds_valid_reg;
    logic [61:0]        ds_disc_reg;
    cri_pkg::sqrt_tag_t ds_tag_reg;
    cri_pkg::sqrt_word_t sw [0:N_SQRT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ds_disc_reg <= sq_rr_reg - sq_pp_reg;
            ds_tag_reg  <= sq_tag_reg;
        end
    end

    always_comb
    begin
        sw[0].valid = ds_valid_reg;
        sw[0].rem   = 64'(ds_disc_reg);
        sw[0].res   = 64'd0;
        sw[0].tag   = ds_tag_reg;
    end

    // square root chain
    for (genvar k = 0; k < N_SQRT; k++)
    begin : g_sqrt
        cri_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .step     (5'(k)),
            .in_word  (sw[k]),
            .out_word (sw[k+1])
        );
    end

    // root selection
    logic               rt_valid_reg;
    logic signed [37:0] s_val, nb, t1, t2, t_sel;
    logic               t1_ok, t2_ok;
    logic signed [37:0] rt_t_reg;
    logic               rt_hit_reg;
    logic signed [31:0] rt_ox_reg, rt_oy_reg, rt_dx_reg, rt_dy_reg;

    always_comb
    begin
        s_val = 38'(sw[N_SQRT].res[31:0]);
        nb    = -38'(sw[N_SQRT].tag.b);
        t1    = nb - s_val;
        t2    = nb + s_val;
        t1_ok = t1 > 38'(cri_pkg::EPS_Q);
        t2_ok = t2 > 38'(cri_pkg::EPS_Q);
        t_sel = t1_ok ? t1 : t2;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rt_t_reg   <= t_sel;
            rt_hit_reg <= !sw[N_SQRT].tag.miss && (t1_ok || t2_ok);
            rt_ox_reg  <= sw[N_SQRT].tag.ox;
            rt_oy_reg  <= sw[N_SQRT].tag.oy;
            rt_dx_reg  <= sw[N_SQRT].tag.dx;
            rt_dy_reg  <= sw[N_SQRT].tag.dy;
        end
    end

    // hit point products
    logic               tm_valid_reg;
    logic signed [69:0] tm_tx_reg, tm_ty_reg;
    logic signed [37:0] tm_t_reg;
    logic               tm_hit_reg;
    logic signed [31:0] tm_ox_reg, tm_oy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tm_tx_reg  <= rt_t_reg * rt_dx_reg;
            tm_ty_reg  <= rt_t_reg * rt_dy_reg;
            tm_t_reg   <= rt_t_reg;
            tm_hit_reg <= rt_hit_reg;
            tm_ox_reg  <= rt_ox_reg;
            tm_oy_reg  <= rt_oy_reg;
        end
    end

    // rounding, saturation and miss zeroing
    logic signed [69:0] rnd_tx, rnd_ty;
    logic signed [41:0] sum_x, sum_y;
    cri_pkg::out_word_t fin_word;

    always_comb
    begin
        rnd_tx = (tm_tx_reg + 70'sd268435456) >>> cri_pkg::DIR_FRAC;
        rnd_ty = (tm_ty_reg + 70'sd268435456) >>> cri_pkg::DIR_FRAC;
        sum_x  = 42'(tm_ox_reg) + 42'($signed(rnd_tx[40:0]));
        sum_y  = 42'(tm_oy_reg) + 42'($signed(rnd_ty[40:0]));
        fin_word = '0;
        if (tm_hit_reg)
        begin
            fin_word.hit = 1'b1;
            if (|tm_t_reg[37:31])
                fin_word.t_dist = 31'h7FFF_FFFF;
            else
                fin_word.t_dist = tm_t_reg[30:0];
            if (sum_x > 42'sd2147483647)
                fin_word.px = 32'sh7FFF_FFFF;
            else if (sum_x < -42'sd2147483648)
                fin_word.px = 32'sh8000_0000;
            else
                fin_word.px = sum_x[31:0];
            if (sum_y > 42'sd2147483647)
                fin_word.py = 32'sh7FFF_FFFF;
            else if (sum_y < -42'sd2147483648)
                fin_word.py = 32'sh8000_0000;
            else
                fin_word.py = sum_y[31:0];
        end
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
            bp_valid_reg  <= 1'b0;
            sq_valid_reg  <= 1'b0;
            ds_valid_reg  <= 1'b0;
            rt_valid_reg  <= 1'b0;
            tm_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            dir_valid_reg <= cw[N_CORDIC].valid;
            mul_valid_reg <= dir_valid_reg;
            bp_valid_reg  <= mul_valid_reg;
            sq_valid_reg  <= bp_valid_reg;
            ds_valid_reg  <= sq_valid_reg;
            rt_valid_reg  <= sw[N_SQRT].valid;
            tm_valid_reg  <= rt_valid_reg;
        end
    end

    // output buffer
    cri_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (tm_valid_reg && en),
        .push_word (fin_word),
        .pop       (out_valid && !out_stall),
        .full      (buf_full),
        .valid     (out_valid),
        .head      (out_head)
    );

    assign hit        = out_head.hit;
    assign distance_t = out_head.t_dist;
    assign point_x    = out_head.px;
    assign point_y    = out_head.py;

`ifndef NO_ASSERTIONS
    // a miss word carries only zeros
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (distance_t == 31'd0 && point_x == 32'd0
                                 && point_y == 32'd0))
        else $error("miss word not zero");

    // a hit is strictly forward
    a_hit_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hit) |-> (distance_t != 31'd0))
        else $error("hit with zero distance");

    // a frozen pipeline keeps its tail
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(tm_valid_reg) && $stable(rt_valid_reg))
        else $error("pipeline moved while frozen");

    // pipeline tail flows into the buffer
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (en && rt_valid_reg) |=> tm_valid_reg)
        else $error("word lost before buffer");
`endif

endmodule
